// ===== rtl/tgarle_pkg.sv =====
// Package for the TGA truecolor RLE decoder: result codes, header layout
// and the registered result record. No dependencies.
`timescale 1ns / 1ps

package tgarle_pkg;

   // result kinds
   localparam logic [1:0] KIND_PIXEL = 2'd0;
   localparam logic [1:0] KIND_INFO  = 2'd1;
   localparam logic [1:0] KIND_ERROR = 2'd2;

   // accepted image types
   localparam logic [7:0] IMG_RAW = 8'd2;
   localparam logic [7:0] IMG_RLE = 8'd10;

   // header byte offsets
   localparam logic [4:0] HDR_ID_LEN   = 5'd0;
   localparam logic [4:0] HDR_MAP_TYPE = 5'd1;
   localparam logic [4:0] HDR_IMG_TYPE = 5'd2;
   localparam logic [4:0] HDR_MAP_LEN0 = 5'd5;
   localparam logic [4:0] HDR_MAP_LEN1 = 5'd6;
   localparam logic [4:0] HDR_WIDTH0   = 5'd12;
   localparam logic [4:0] HDR_WIDTH1   = 5'd13;
   localparam logic [4:0] HDR_HEIGHT0  = 5'd14;
   localparam logic [4:0] HDR_HEIGHT1  = 5'd15;
   localparam logic [4:0] HDR_DEPTH    = 5'd16;
   localparam logic [4:0] HDR_LAST     = 5'd17;

   localparam logic [6:0] RLE_COUNT_MASK = 7'h7f;
   localparam logic [2:0] MAX_CHANNELS   = 3'd4;
   localparam logic [2:0] SWAP_CHANNELS  = 3'd3;

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  byte0;
      logic [7:0]  byte1;
      logic [7:0]  byte2;
      logic [7:0]  byte3;
      logic [7:0]  repeat_res;
      logic [15:0] width;
      logic [15:0] height;
      logic [2:0]  channels;
      logic        last;
   } rsp_payload_type;

endpackage

// ===== rtl/tgarle_req_if.sv =====
// Byte input channel of the TGA decoder: valid/ready plus one file byte.
// No dependencies.
`timescale 1ns / 1ps

interface tgarle_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       first_byte;

   modport source (output valid, output data_byte, output first_byte, input ready);
   modport sink   (input valid, input data_byte, input first_byte, output ready);
endinterface

// ===== rtl/tgarle_rsp_if.sv =====
// Result channel of the TGA decoder: valid/ready plus one result record.
// No dependencies.
`timescale 1ns / 1ps

interface tgarle_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [7:0]  byte0;
   logic [7:0]  byte1;
   logic [7:0]  byte2;
   logic [7:0]  byte3;
   logic [7:0]  repeat_res;
   logic [15:0] width;
   logic [15:0] height;
   logic [2:0]  channels;
   logic        last;

   modport source (output valid, output kind, output byte0, output byte1, output byte2,
                   output byte3, output repeat_res, output width, output height,
                   output channels, output last, input ready);
   modport sink   (input valid, input kind, input byte0, input byte1, input byte2,
                   input byte3, input repeat_res, input width, input height,
                   input channels, input last, output ready);
endinterface

// ===== rtl/tga_truecolor_rle_decoder_top.sv =====
// Top level of the TGA truecolor RLE decoder.
// Depends on tgarle_pkg, tgarle_req_if and tgarle_rsp_if.
`timescale 1ns / 1ps

// Takes one byte of a TGA file per clock while the skid entry is empty, and
// returns at most one result per byte: an info or error record when the
// 18-byte header ends, then one pixel run per raw pixel, per pixel of an RLE
// raw packet or per RLE run packet, clipped at width * height. A byte with
// first_byte set restarts the parser at header byte zero. The decoder accepts
// a byte every cycle while the skid entry is empty; the result that a byte
// completes is registered in the result register, which is backed by one skid
// entry, so a stalled consumer stops input only once both are full. Nothing needs clearing after reset.
module tga_truecolor_rle_decoder_top
   import tgarle_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   tgarle_req_if.sink    req_if,
   tgarle_rsp_if.source  rsp_if
);

   typedef enum logic [1:0] {PH_HEADER, PH_SKIP, PH_DATA, PH_IDLE} phase_type;

   phase_type   phase_ff, phase_in, cur_phase;
   logic [4:0]  hdr_idx_ff, hdr_idx_in, cur_hdr_idx;
   logic [7:0]  id_len_ff, id_len_in, cur_id_len;
   logic [7:0]  map_type_ff, map_type_in, cur_map_type;
   logic [7:0]  img_kind_ff, img_kind_in, cur_img_kind;
   logic [15:0] map_len_ff, map_len_in, cur_map_len;
   logic [15:0] img_w_ff, img_w_in, cur_img_w;
   logic [15:0] img_h_ff, img_h_in, cur_img_h;
   logic [2:0]  pix_bytes_ff, pix_bytes_in, cur_pix_bytes;
   logic [23:0] skip_ff, skip_in, cur_skip;
   logic [31:0] pix_left_ff, pix_left_in, cur_pix_left;
   logic [7:0]  pkt_left_ff, pkt_left_in, cur_pkt_left;
   logic        pkt_run_ff, pkt_run_in, cur_pkt_run;
   logic [31:0] pix_buf_ff, pix_buf_in, cur_pix_buf;
   logic [1:0]  bip_ff, bip_in, cur_bip;

   logic        accept;
   logic        first;
   logic [7:0]  din;
   logic        res_valid;
   rsp_payload_type res;

   logic [23:0] skip_prod;
   logic [31:0] area_prod;
   logic        skip_nz;
   logic        area_zero;
   logic        fmt_ok;
   logic [4:0]  depth_bytes;
   logic [31:0] buf_new;
   logic [2:0]  bip_inc;
   logic [7:0]  rep_raw;
   logic [7:0]  rep_clip;
   logic        rep_last;
   logic [31:0] pix_out;

   logic            out_valid_ff;
   logic            skid_valid_ff;
   rsp_payload_type out_ff;
   rsp_payload_type skid_ff;
   logic            out_free;

   assign accept = req_if.valid && req_if.ready;
   assign first  = req_if.first_byte;
   assign din    = req_if.data_byte;

   // restart view of the state: first_byte behaves as a reset of the parser
   assign cur_phase     = first ? PH_HEADER : phase_ff;
   assign cur_hdr_idx   = first ? 5'd0  : hdr_idx_ff;
   assign cur_id_len    = first ? 8'd0  : id_len_ff;
   assign cur_map_type  = first ? 8'd0  : map_type_ff;
   assign cur_img_kind  = first ? 8'd0  : img_kind_ff;
   assign cur_map_len   = first ? 16'd0 : map_len_ff;
   assign cur_img_w     = first ? 16'd0 : img_w_ff;
   assign cur_img_h     = first ? 16'd0 : img_h_ff;
   assign cur_pix_bytes = first ? 3'd0  : pix_bytes_ff;
   assign cur_skip      = first ? 24'd0 : skip_ff;
   assign cur_pix_left  = first ? 32'd0 : pix_left_ff;
   assign cur_pkt_left  = first ? 8'd0  : pkt_left_ff;
   assign cur_pkt_run   = first ? 1'b0  : pkt_run_ff;
   assign cur_pix_buf   = first ? 32'd0 : pix_buf_ff;
   assign cur_bip       = first ? 2'd0  : bip_ff;

   // products only matter on the last header byte, where first is never set
   assign skip_prod = {16'd0, id_len_ff} + map_type_ff * map_len_ff;
   assign area_prod = img_w_ff * img_h_ff;
   assign skip_nz   = (id_len_ff != 8'd0) || ((map_type_ff != 8'd0) && (map_len_ff != 16'd0));
   assign area_zero = (img_w_ff == 16'd0) || (img_h_ff == 16'd0);
   assign fmt_ok    = (img_kind_ff inside {IMG_RAW, IMG_RLE}) &&
                      (pix_bytes_ff != 3'd0) && (pix_bytes_ff <= MAX_CHANNELS);
   assign depth_bytes = din[7:3];

   assign buf_new = cur_pix_buf | ({24'd0, din} << {cur_bip, 3'b000});
   assign bip_inc = {1'b0, cur_bip} + 3'd1;
   assign rep_raw = ((cur_img_kind == IMG_RLE) && cur_pkt_run) ? cur_pkt_left : 8'd1;
   assign rep_last = ({24'd0, rep_raw} >= cur_pix_left);
   assign rep_clip = ({24'd0, rep_raw} > cur_pix_left) ? cur_pix_left[7:0] : rep_raw;
   assign pix_out  = (cur_pix_bytes == SWAP_CHANNELS) ?
                     {buf_new[31:24], buf_new[7:0], buf_new[15:8], buf_new[23:16]} :
                     buf_new;

   always_comb begin
      phase_in     = cur_phase;
      hdr_idx_in   = cur_hdr_idx;
      id_len_in    = cur_id_len;
      map_type_in  = cur_map_type;
      img_kind_in  = cur_img_kind;
      map_len_in   = cur_map_len;
      img_w_in     = cur_img_w;
      img_h_in     = cur_img_h;
      pix_bytes_in = cur_pix_bytes;
      skip_in      = cur_skip;
      pix_left_in  = cur_pix_left;
      pkt_left_in  = cur_pkt_left;
      pkt_run_in   = cur_pkt_run;
      pix_buf_in   = cur_pix_buf;
      bip_in       = cur_bip;
      res_valid    = 1'b0;
      res          = '0;

      case (cur_phase)
         PH_HEADER: begin
            case (cur_hdr_idx)
               HDR_ID_LEN:   id_len_in   = din;
               HDR_MAP_TYPE: map_type_in = din;
               HDR_IMG_TYPE: img_kind_in = din;
               HDR_MAP_LEN0: map_len_in  = {cur_map_len[15:8], din};
               HDR_MAP_LEN1: map_len_in  = {din, cur_map_len[7:0]};
               HDR_WIDTH0:   img_w_in    = {cur_img_w[15:8], din};
               HDR_WIDTH1:   img_w_in    = {din, cur_img_w[7:0]};
               HDR_HEIGHT0:  img_h_in    = {cur_img_h[15:8], din};
               HDR_HEIGHT1:  img_h_in    = {din, cur_img_h[7:0]};
               HDR_DEPTH:    pix_bytes_in = (depth_bytes > 5'd7) ? 3'd7 : depth_bytes[2:0];
               default: ;
            endcase
            if (cur_hdr_idx >= HDR_LAST) begin
               hdr_idx_in   = 5'd0;
               res_valid    = 1'b1;
               res.width    = img_w_ff;
               res.height   = img_h_ff;
               res.channels = pix_bytes_ff;
               if (!fmt_ok) begin
                  res.kind = KIND_ERROR;
                  phase_in = PH_IDLE;
               end else begin
                  res.kind    = KIND_INFO;
                  res.last    = area_zero;
                  skip_in     = skip_prod;
                  pix_left_in = area_prod;
                  pkt_left_in = 8'd0;
                  pkt_run_in  = 1'b0;
                  pix_buf_in  = 32'd0;
                  bip_in      = 2'd0;
                  if (area_zero)    phase_in = PH_IDLE;
                  else if (skip_nz) phase_in = PH_SKIP;
                  else              phase_in = PH_DATA;
               end
            end else begin
               hdr_idx_in = cur_hdr_idx + 5'd1;
            end
         end
         PH_SKIP: begin
            if (cur_skip != 24'd0) skip_in = cur_skip - 24'd1;
            if (cur_skip <= 24'd1) phase_in = PH_DATA;
         end
         PH_DATA: begin
            if ((cur_img_kind == IMG_RLE) && (cur_pkt_left == 8'd0)) begin
               pkt_left_in = {1'b0, din[6:0] & RLE_COUNT_MASK} + 8'd1;
               pkt_run_in  = din[7];
            end else if (bip_inc < cur_pix_bytes) begin
               pix_buf_in = buf_new;
               bip_in     = bip_inc[1:0];
            end else begin
               bip_in     = 2'd0;
               pix_buf_in = 32'd0;
               if (cur_img_kind == IMG_RLE) begin
                  pkt_left_in = cur_pkt_run ? 8'd0 : cur_pkt_left - 8'd1;
               end
               pix_left_in    = cur_pix_left - {24'd0, rep_clip};
               res_valid      = 1'b1;
               res.kind       = KIND_PIXEL;
               res.byte0      = pix_out[7:0];
               res.byte1      = pix_out[15:8];
               res.byte2      = pix_out[23:16];
               res.byte3      = pix_out[31:24];
               res.repeat_res = rep_clip;
               res.last       = rep_last;
               if (rep_last) phase_in = PH_IDLE;
            end
         end
         default: ;
      endcase
   end

   // result register plus one skid entry; input stalls only when the skid is full
   assign out_free     = !out_valid_ff || rsp_if.ready;
   assign req_if.ready = !skid_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_HEADER;
         hdr_idx_ff    <= 5'd0;
         id_len_ff     <= 8'd0;
         map_type_ff   <= 8'd0;
         img_kind_ff   <= 8'd0;
         map_len_ff    <= 16'd0;
         img_w_ff      <= 16'd0;
         img_h_ff      <= 16'd0;
         pix_bytes_ff  <= 3'd0;
         skip_ff       <= 24'd0;
         pix_left_ff   <= 32'd0;
         pkt_left_ff   <= 8'd0;
         pkt_run_ff    <= 1'b0;
         pix_buf_ff    <= 32'd0;
         bip_ff        <= 2'd0;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            phase_ff     <= phase_in;
            hdr_idx_ff   <= hdr_idx_in;
            id_len_ff    <= id_len_in;
            map_type_ff  <= map_type_in;
            img_kind_ff  <= img_kind_in;
            map_len_ff   <= map_len_in;
            img_w_ff     <= img_w_in;
            img_h_ff     <= img_h_in;
            pix_bytes_ff <= pix_bytes_in;
            skip_ff      <= skip_in;
            pix_left_ff  <= pix_left_in;
            pkt_left_ff  <= pkt_left_in;
            pkt_run_ff   <= pkt_run_in;
            pix_buf_ff   <= pix_buf_in;
            bip_ff       <= bip_in;
         end
         if (out_free) begin
            if (skid_valid_ff) begin
               out_ff        <= skid_ff;
               out_valid_ff  <= 1'b1;
               skid_valid_ff <= 1'b0;
            end else begin
               out_valid_ff <= accept && res_valid;
               if (accept && res_valid) out_ff <= res;
            end
         end else if (accept && res_valid) begin
            skid_ff       <= res;
            skid_valid_ff <= 1'b1;
         end
      end
   end

   assign rsp_if.valid      = out_valid_ff;
   assign rsp_if.kind       = out_ff.kind;
   assign rsp_if.byte0      = out_ff.byte0;
   assign rsp_if.byte1      = out_ff.byte1;
   assign rsp_if.byte2      = out_ff.byte2;
   assign rsp_if.byte3      = out_ff.byte3;
   assign rsp_if.repeat_res = out_ff.repeat_res;
   assign rsp_if.width      = out_ff.width;
   assign rsp_if.height     = out_ff.height;
   assign rsp_if.channels   = out_ff.channels;
   assign rsp_if.last       = out_ff.last;

`ifndef SYNTHESIS
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry held while result register empty");

   a_last_goes_idle: assert property (@(posedge clock) disable iff (reset)
      (accept && res_valid && res.last) |=> (phase_ff == PH_IDLE))
      else $error("parser not idle after final result");

   a_run_length: assert property (@(posedge clock) disable iff (reset)
      (accept && res_valid && (res.kind == KIND_PIXEL)) |->
      ((res.repeat_res != 8'd0) && (res.repeat_res <= 8'd128)))
      else $error("pixel run length out of range");

   a_byte_slot: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_DATA) |-> ({1'b0, bip_ff} < pix_bytes_ff))
      else $error("byte slot beyond pixel size");

   a_info_leaves_header: assert property (@(posedge clock) disable iff (reset)
      (accept && res_valid && (res.kind == KIND_INFO) && !res.last) |=>
      ((phase_ff == PH_SKIP) || (phase_ff == PH_DATA)))
      else $error("header accepted but no skip or data phase");
`endif

endmodule
